// ----- design/ccptc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccptc_pkg
// Shared constants, types and a saturating arithmetic helper for the cubic curve unit.
// ---------------------------------------------------------------------------
package ccptc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ROT_BITS      = 30;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_U_AB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_U_CD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_AB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_CD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PBND   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCTOL  = 3'd7;

  typedef struct packed {
    logic signed [31:0] ua, ub, uc, ud;
    logic signed [31:0] va, vb, vc, vd;
    logic signed [31:0] x0, y0;
    logic signed [31:0] cs, sn;
    logic signed [31:0] p0, p1;
    logic signed [31:0] scale;
    logic        [31:0] tol;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ----- design/ccptc_mac.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccptc_mac
// Registered Horner step: sat(coef + ((t * acc) >> FRAC_BITS)).
// ---------------------------------------------------------------------------
module ccptc_mac import ccptc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] coef,
  input  logic signed [31:0] t,
  input  logic signed [31:0] acc,
  output logic signed [31:0] res_r
);
  logic signed [63:0] prod;
  logic signed [65:0] sum;

  assign prod = t * acc;
  assign sum  = 66'(coef) + 66'(prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    res_r <= sat32(sum);
  end
endmodule

// ----- design/ccptc_rot.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccptc_rot
// Registered rotation by Q2.30 cos/sin: two products per output, one stage.
// ---------------------------------------------------------------------------
module ccptc_rot import ccptc_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] u,
  input  logic signed [31:0] v,
  input  logic signed [31:0] cs,
  input  logic signed [31:0] sn,
  output logic signed [31:0] rx_r,
  output logic signed [31:0] ry_r
);
  logic signed [64:0] ax, ay;

  assign ax = 65'(u * cs) - 65'(v * sn);
  assign ay = 65'(u * sn) + 65'(v * cs);

  always_ff @(posedge clk) begin
    rx_r <= sat32(66'(ax >>> ROT_BITS));
    ry_r <= sat32(66'(ay >>> ROT_BITS));
  end
endmodule

// ----- design/ccptc_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccptc_div
// Pipelined signed divide, one quotient bit per stage, truncation toward
// zero, saturated to 32 bits. Carries a sideband word alongside.
// ---------------------------------------------------------------------------
module ccptc_div import ccptc_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [64:0] num,
  input  logic        [63:0] den,
  input  logic [SB_W-1:0]    in_sb,
  output logic               out_vld,
  output logic signed [31:0] quo,
  output logic [SB_W-1:0]    out_sb
);
  localparam int QW = 65;

  logic [QW-1:0]   rem_r [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic [63:0]     d_r   [QW+1];
  logic            neg_r [QW+1];
  logic            zero_r[QW+1];
  logic            v_r   [QW+1];
  logic [SB_W-1:0] sb_r  [QW+1];

  logic [QW-1:0] mag;
  assign mag = num[64] ? QW'(-num) : QW'(num);

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    q_r[0]    <= mag;
    d_r[0]    <= den;
    neg_r[0]  <= num[64];
    zero_r[0] <= (den == '0);
    sb_r[0]   <= in_sb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= in_vld;
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW:0] trial;
    assign trial = {rem_r[i], q_r[i][QW-1]} - {2'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (!trial[QW]) begin
        rem_r[i+1] <= trial[QW-1:0];
        q_r[i+1]   <= {q_r[i][QW-2:0], 1'b1};
      end else begin
        rem_r[i+1] <= {rem_r[i][QW-2:0], q_r[i][QW-1]};
        q_r[i+1]   <= {q_r[i][QW-2:0], 1'b0};
      end
      d_r[i+1]    <= d_r[i];
      neg_r[i+1]  <= neg_r[i];
      zero_r[i+1] <= zero_r[i];
      sb_r[i+1]   <= sb_r[i];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_r[i];
    end
  end

  logic signed [65:0] sq;
  assign sq = neg_r[QW] ? -$signed({1'b0, q_r[QW]}) : $signed({1'b0, q_r[QW]});
  assign quo     = zero_r[QW] ? '0 : sat32(sq);
  assign out_vld = v_r[QW];
  assign out_sb  = sb_r[QW];
endmodule

// ----- design/cubic_curve_point_tangent_curvature_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_curve_point_tangent_curvature_unit
// Pipeline: 10 stages up to the curvature numerator/denominator, then the
// 65-stage divider, whose valid output drives out_valid.
// One beat accepted per cycle; busy stays low; out_valid is a one-cycle
// strobe, the receiver never stalls.
// Synchronous active-low reset clears valid bits and config to defaults.
// ---------------------------------------------------------------------------
module cubic_curve_point_tangent_curvature_unit import ccptc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_p,
  output logic                  out_valid,
  output logic signed [31:0]    out_x,
  output logic signed [31:0]    out_y,
  output logic signed [31:0]    out_dx,
  output logic signed [31:0]    out_dy,
  output logic signed [31:0]    out_curvature,
  output logic                  out_out_of_range,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int NST = 9;            // last stage before divider
  localparam int SB_W = 32*4 + 1;

  logic [CFG_DATA_W-1:0] reg_r [8];
  cfg_t c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[REG_U_AB]   <= '0;
      reg_r[REG_U_CD]   <= '0;
      reg_r[REG_V_AB]   <= '0;
      reg_r[REG_V_CD]   <= '0;
      reg_r[REG_ORIGIN] <= '0;
      reg_r[REG_ROT]    <= 64'h4000_0000_0000_0000;
      reg_r[REG_PBND]   <= 64'(1) << FRAC_BITS;
      reg_r[REG_SCTOL]  <= 64'(1) << (32 + FRAC_BITS);
    end else if (cfg_we) begin
      reg_r[cfg_idx] <= cfg_data;
    end
  end

  assign c.ua = reg_r[REG_U_AB][63:32];  assign c.ub = reg_r[REG_U_AB][31:0];
  assign c.uc = reg_r[REG_U_CD][63:32];  assign c.ud = reg_r[REG_U_CD][31:0];
  assign c.va = reg_r[REG_V_AB][63:32];  assign c.vb = reg_r[REG_V_AB][31:0];
  assign c.vc = reg_r[REG_V_CD][63:32];  assign c.vd = reg_r[REG_V_CD][31:0];
  assign c.x0 = reg_r[REG_ORIGIN][63:32]; assign c.y0 = reg_r[REG_ORIGIN][31:0];
  assign c.cs = reg_r[REG_ROT][63:32];   assign c.sn = reg_r[REG_ROT][31:0];
  assign c.p0 = reg_r[REG_PBND][63:32];  assign c.p1 = reg_r[REG_PBND][31:0];
  assign c.scale = reg_r[REG_SCTOL][63:32];
  assign c.tol   = reg_r[REG_SCTOL][31:0];

  assign busy = 1'b0;

  // valid and out_of_range shift line
  logic v_r [NST+1];
  logic o_r [NST+1];

  // stage 0: clamp
  logic signed [32:0] dlo, dhi;
  logic signed [31:0] pc;
  logic               oor;
  always_comb begin
    dlo = 33'(c.p0) - 33'(in_p);
    dhi = 33'(in_p) - 33'(c.p1);
    pc  = in_p;
    oor = 1'b0;
    if (in_p < c.p0) begin
      pc  = c.p0;
      oor = dlo > $signed({1'b0, c.tol});
    end else if (in_p > c.p1) begin
      pc  = c.p1;
      oor = dhi > $signed({1'b0, c.tol});
    end
  end

  logic signed [31:0] off_r, t_r;
  always_ff @(posedge clk) begin
    off_r <= sat32(66'(pc) - 66'(c.p0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= start;
    o_r[0] <= oor;
  end
  for (genvar i = 0; i < NST; i++) begin : g_sb
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_r[i];
      o_r[i+1] <= o_r[i];
    end
  end

  // stage 1: t
  logic signed [63:0] tp;
  assign tp = off_r * c.scale;
  always_ff @(posedge clk) t_r <= sat32(66'(tp >>> FRAC_BITS));

  // pre-scaled coefficients
  logic signed [31:0] uc2, vc2, ud3, vd3, ud6, vd6;
  assign uc2 = sat32(66'(c.uc) * 66'sd2);
  assign vc2 = sat32(66'(c.vc) * 66'sd2);
  assign ud3 = sat32(66'(c.ud) * 66'sd3);
  assign vd3 = sat32(66'(c.vd) * 66'sd3);
  assign ud6 = sat32(66'(c.ud) * 66'sd6);
  assign vd6 = sat32(66'(c.vd) * 66'sd6);

  // stages 2..4: Horner, t delayed alongside
  logic signed [31:0] t2_r, t3_r;
  always_ff @(posedge clk) begin
    t2_r <= t_r;
    t3_r <= t2_r;
  end

  logic signed [31:0] hu1, hu2, hu, hv1, hv2, hv;
  logic signed [31:0] hd1, hd, hw1, hw;
  logic signed [31:0] hs, hz, hs_r, hz_r;
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m0 (.clk, .coef(c.uc), .t(t_r),  .acc(c.ud), .res_r(hu1));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m1 (.clk, .coef(c.ub), .t(t2_r), .acc(hu1),  .res_r(hu2));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m2 (.clk, .coef(c.ua), .t(t3_r), .acc(hu2),  .res_r(hu));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m3 (.clk, .coef(c.vc), .t(t_r),  .acc(c.vd), .res_r(hv1));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m4 (.clk, .coef(c.vb), .t(t2_r), .acc(hv1),  .res_r(hv2));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m5 (.clk, .coef(c.va), .t(t3_r), .acc(hv2),  .res_r(hv));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m6 (.clk, .coef(uc2),  .t(t_r),  .acc(ud3),  .res_r(hd1));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m7 (.clk, .coef(c.ub), .t(t2_r), .acc(hd1),  .res_r(hd));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m8 (.clk, .coef(vc2),  .t(t_r),  .acc(vd3),  .res_r(hw1));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) m9 (.clk, .coef(c.vb), .t(t2_r), .acc(hw1),  .res_r(hw));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) ma (.clk, .coef(uc2),  .t(t_r),  .acc(ud6),  .res_r(hs));
  ccptc_mac #(.FRAC_BITS(FRAC_BITS)) mb (.clk, .coef(vc2),  .t(t_r),  .acc(vd6),  .res_r(hz));

  // align first and second derivative to the point (after stage 4)
  logic signed [31:0] hd_r, hw_r, hs2_r, hz2_r;
  always_ff @(posedge clk) begin
    hd_r  <= hd;
    hw_r  <= hw;
    hs_r  <= hs;
    hz_r  <= hz;
    hs2_r <= hs_r;
    hz2_r <= hz_r;
  end

  // stage 5: rotations
  logic signed [31:0] lx0, ly0, lx1, ly1, lx2, ly2;
  ccptc_rot r0 (.clk, .u(hu),    .v(hv),    .cs(c.cs), .sn(c.sn), .rx_r(lx0), .ry_r(ly0));
  ccptc_rot r1 (.clk, .u(hd_r),  .v(hw_r),  .cs(c.cs), .sn(c.sn), .rx_r(lx1), .ry_r(ly1));
  ccptc_rot r2 (.clk, .u(hs2_r), .v(hz2_r), .cs(c.cs), .sn(c.sn), .rx_r(lx2), .ry_r(ly2));

  // stage 6: offset and scale
  logic signed [31:0] x_r, y_r, dx_r, dy_r, ex_r, ey_r;
  always_ff @(posedge clk) begin
    x_r  <= sat32(66'(c.x0) + 66'(lx0));
    y_r  <= sat32(66'(c.y0) + 66'(ly0));
    dx_r <= sat32(66'((lx1 * c.scale) >>> FRAC_BITS));
    dy_r <= sat32(66'((ly1 * c.scale) >>> FRAC_BITS));
    ex_r <= sat32(66'((lx2 * c.scale) >>> FRAC_BITS));
    ey_r <= sat32(66'((ly2 * c.scale) >>> FRAC_BITS));
  end

  // stage 7: second scale of second derivative
  logic signed [31:0] x2_r, y2_r, dx2_r, dy2_r, ddx_r, ddy_r;
  always_ff @(posedge clk) begin
    x2_r  <= x_r;   y2_r  <= y_r;
    dx2_r <= dx_r;  dy2_r <= dy_r;
    ddx_r <= sat32(66'((ex_r * c.scale) >>> FRAC_BITS));
    ddy_r <= sat32(66'((ey_r * c.scale) >>> FRAC_BITS));
  end

  // stage 8: products
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [31:0] x3_r, y3_r, dx3_r, dy3_r;
  always_ff @(posedge clk) begin
    pa_r <= dx2_r * ddy_r;
    pb_r <= dy2_r * ddx_r;
    pc_r <= dx2_r * dx2_r;
    pd_r <= dy2_r * dy2_r;
    x3_r <= x2_r; y3_r <= y2_r; dx3_r <= dx2_r; dy3_r <= dy2_r;
  end

  // stage 9: numerator, denominator
  logic signed [64:0] num_r;
  logic        [63:0] den_r;
  logic        [63:0] dsum;
  logic signed [31:0] x4_r, y4_r, dx4_r, dy4_r;
  assign dsum = 64'(pc_r) + 64'(pd_r);
  always_ff @(posedge clk) begin
    num_r <= 65'(pa_r) - 65'(pb_r);
    den_r <= dsum >> FRAC_BITS;
    x4_r <= x3_r; y4_r <= y3_r; dx4_r <= dx3_r; dy4_r <= dy3_r;
  end

  // v_r/o_r index NST is loaded on the same edge as stage 9
  logic [SB_W-1:0] sb_in, sb_out;
  logic            dv;
  logic signed [31:0] q;
  assign sb_in = {o_r[NST], x4_r, y4_r, dx4_r, dy4_r};

  ccptc_div #(.SB_W(SB_W)) u_div (
    .clk, .rst_n, .in_vld(v_r[NST]), .num(num_r), .den(den_r),
    .in_sb(sb_in), .out_vld(dv), .quo(q), .out_sb(sb_out)
  );

  assign out_valid        = dv;
  assign out_curvature    = q;
  assign out_out_of_range = sb_out[SB_W-1];
  assign out_x            = sb_out[127:96];
  assign out_y            = sb_out[95:64];
  assign out_dx           = sb_out[63:32];
  assign out_dy           = sb_out[31:0];
endmodule
